// ===== design/lts_pkg.sv =====
`timescale 1ns / 1ps

package lts_pkg;

	localparam int LINE_W  = 32;
	localparam int CFG_W   = 31;
	localparam int OFF_W   = 31;
	localparam int SHIFT_W = 6;

	localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};

	// entry codes
	localparam logic [3:0] CODE_LINE_ADD0 = 4'd10;
	localparam logic [3:0] CODE_LINE_ADD2 = 4'd12;
	localparam logic [3:0] CODE_DELTA_A   = 4'd13;
	localparam logic [3:0] CODE_DELTA_B   = 4'd14;
	localparam logic [3:0] CODE_NO_LINE   = 4'd15;

	localparam logic [SHIFT_W-1:0] SHIFT_STEP  = 6'd6;
	localparam logic [SHIFT_W-1:0] SHIFT_CAP   = 6'd36;
	localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = 6'd32;

	// configuration register indexes
	localparam logic CFG_FIRST_LINE  = 1'b0;
	localparam logic CFG_TARGET_LINE = 1'b1;

	// result status codes
	localparam logic ST_FOUND     = 1'b0;
	localparam logic ST_NOT_FOUND = 1'b1;

	typedef enum logic [1:0] {
		PH_WAIT   = 2'd0,
		PH_VARINT = 2'd1,
		PH_SKIP   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [LINE_W-1:0]  current_line;
		logic [OFF_W-1:0]   entry_start;
		logic [OFF_W-1:0]   entry_end;
		logic [LINE_W-1:0]  varint_accum;
		logic [SHIFT_W-1:0] varint_shift;
		phase_t             parse_phase;
		logic               search_done;
	} parse_state_t;

	typedef struct packed {
		logic             status;
		logic [OFF_W-1:0] byte_offset;
	} result_t;

	// zigzag delta: bit 0 is the sign, the rest the magnitude
	function automatic logic [LINE_W-1:0] apply_delta(input logic [LINE_W-1:0] line,
			input logic [LINE_W-1:0] accum);
		logic [LINE_W-1:0] mag;
		mag = {1'b0, accum[LINE_W-1:1]};
		return accum[0] ? line - mag : line + mag;
	endfunction

	function automatic parse_state_t start_state(input logic [CFG_W-1:0] first_line);
		parse_state_t s;
		s.current_line = {1'b0, first_line};
		s.entry_start  = '0;
		s.entry_end    = '0;
		s.varint_accum = '0;
		s.varint_shift = '0;
		s.parse_phase  = PH_WAIT;
		s.search_done  = 1'b0;
		return s;
	endfunction

endpackage

// ===== design/lts_if.sv =====
`timescale 1ns / 1ps

interface lts_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] table_byte;
	logic       last_byte;
	modport source(output valid, output table_byte, output last_byte, input ready);
	modport sink(input valid, input table_byte, input last_byte, output ready);
endinterface

interface lts_result_if;
	logic                      valid;
	logic                      ready;
	logic                      status;
	logic [lts_pkg::OFF_W-1:0] byte_offset;
	modport source(output valid, output status, output byte_offset, input ready);
	modport sink(input valid, input status, input byte_offset, output ready);
endinterface

interface lts_cfg_if;
	logic                      valid;
	logic                      ready;
	logic                      index;
	logic [lts_pkg::CFG_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== design/lts_cfg.sv =====
`timescale 1ns / 1ps

module lts_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	lts_cfg_if.sink                   cfg,
	output logic [lts_pkg::CFG_W-1:0] first_line,
	output logic [lts_pkg::CFG_W-1:0] target_line
);
	import lts_pkg::*;

	logic [CFG_W-1:0] first_line_q;
	logic [CFG_W-1:0] target_line_q;

	assign cfg.ready   = 1'b1;
	assign first_line  = first_line_q;
	assign target_line = target_line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_line_q  <= CFG_W'(1);
			target_line_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_FIRST_LINE:  first_line_q  <= cfg.data;
				CFG_TARGET_LINE: target_line_q <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

// ===== design/lts_step.sv =====
`timescale 1ns / 1ps

module lts_step (
	input  lts_pkg::parse_state_t     st,
	input  logic [7:0]                table_byte,
	input  logic                      last_byte,
	input  logic [lts_pkg::CFG_W-1:0] first_line,
	input  logic [lts_pkg::CFG_W-1:0] target_line,
	output lts_pkg::parse_state_t     nst,
	output logic                      res_valid,
	output lts_pkg::result_t          res
);
	import lts_pkg::*;

	logic [3:0]        code;
	logic [3:0]        units;
	logic [4:0]        len;
	logic [OFF_W:0]    end_sum;
	logic [LINE_W-1:0] target_ext;
	logic [LINE_W-1:0] chunk;
	logic [3:0]        add_lines;

	assign code       = table_byte[6:3];
	assign units      = {1'b0, table_byte[2:0]} + 4'd1;
	assign len        = {units, 1'b0};
	assign end_sum    = {1'b0, st.entry_end} + {{(OFF_W-4){1'b0}}, len};
	assign target_ext = {1'b0, target_line};
	assign chunk      = {{(LINE_W-6){1'b0}}, table_byte[5:0]} << st.varint_shift;
	assign add_lines  = code - CODE_LINE_ADD0;

	always_comb begin
		nst       = st;
		res_valid = 1'b0;
		res       = '{status: ST_FOUND, byte_offset: '0};

		if (table_byte[7]) begin
			// entry header: close any open varint first
			if (st.parse_phase == PH_VARINT) begin
				nst.current_line = apply_delta(st.current_line, st.varint_accum);
				nst.varint_accum = '0;
				nst.varint_shift = '0;
				if (!st.search_done && nst.current_line == target_ext) begin
					res_valid       = 1'b1;
					res.byte_offset = st.entry_start;
					nst.search_done = 1'b1;
				end
			end
			if (st.entry_end == '0)
				nst.current_line = {1'b0, first_line};
			nst.entry_start = st.entry_end;
			nst.entry_end   = end_sum[OFF_W] ? OFF_MAX : end_sum[OFF_W-1:0];
			if (code == CODE_DELTA_A || code == CODE_DELTA_B) begin
				nst.varint_accum = '0;
				nst.varint_shift = '0;
				nst.parse_phase  = PH_VARINT;
			end else begin
				if (code >= CODE_LINE_ADD0 && code <= CODE_LINE_ADD2)
					nst.current_line = nst.current_line + {{(LINE_W-4){1'b0}}, add_lines};
				nst.parse_phase = PH_SKIP;
				if (code != CODE_NO_LINE && !res_valid && !nst.search_done
						&& nst.current_line == target_ext) begin
					res_valid       = 1'b1;
					res.byte_offset = st.entry_end;
					nst.search_done = 1'b1;
				end
			end
		end else if (st.parse_phase == PH_VARINT) begin
			if (st.varint_shift < SHIFT_LIMIT)
				nst.varint_accum = st.varint_accum | chunk;
			if (table_byte[6]) begin
				if (st.varint_shift < SHIFT_CAP)
					nst.varint_shift = st.varint_shift + SHIFT_STEP;
			end else begin
				nst.current_line = apply_delta(st.current_line, nst.varint_accum);
				nst.varint_accum = '0;
				nst.varint_shift = '0;
				nst.parse_phase  = PH_SKIP;
				if (!st.search_done && nst.current_line == target_ext) begin
					res_valid       = 1'b1;
					res.byte_offset = st.entry_start;
					nst.search_done = 1'b1;
				end
			end
		end

		if (last_byte) begin
			// end of table closes an open varint
			if (nst.parse_phase == PH_VARINT && !res_valid && !nst.search_done
					&& apply_delta(nst.current_line, nst.varint_accum) == target_ext) begin
				res_valid       = 1'b1;
				res.byte_offset = nst.entry_start;
				nst.search_done = 1'b1;
			end
			if (!nst.search_done && !res_valid) begin
				res_valid  = 1'b1;
				res.status = ST_NOT_FOUND;
			end
			nst = start_state(first_line);
		end
	end

endmodule

// ===== design/location_table_line_search_core.sv =====
`timescale 1ns / 1ps
// channel  dir  payload                     handshake
// tbl      in   table_byte, last_byte       valid/ready
// result   out  status, byte_offset         valid/ready
// cfg      in   index, data                 valid/ready (ready always high)
//
// one byte per cycle sustained while the result output is not stalled; a taken byte
// passes through the input register, then its result through the result register
// the parse state updates in one step of logic between those registers
// reset clears control state and loads first_line = 1, target_line = 0
// a result held on a stalled output holds the byte in the input register,
// and tbl ready stays low until the result is taken

module location_table_line_search_core (
	input  logic        clk,
	input  logic        arst_n,
	lts_byte_if.sink    tbl,
	lts_result_if.source result,
	lts_cfg_if.sink     cfg
);
	import lts_pkg::*;

	logic [CFG_W-1:0] first_line;
	logic [CFG_W-1:0] target_line;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	parse_state_t state_q;
	parse_state_t state_nxt;
	logic         res_valid;
	result_t      res_nxt;

	logic       out_valid_q;
	result_t    out_q;
	logic       advance;

	lts_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.first_line  (first_line),
		.target_line (target_line)
	);

	lts_step u_step (
		.st          (state_q),
		.table_byte  (byte_s1),
		.last_byte   (last_s1),
		.first_line  (first_line),
		.target_line (target_line),
		.nst         (state_nxt),
		.res_valid   (res_valid),
		.res         (res_nxt)
	);

	assign advance   = valid_s1 && (!out_valid_q || result.ready);
	assign tbl.ready = !valid_s1 || advance;

	assign result.valid       = out_valid_q;
	assign result.status      = out_q.status;
	assign result.byte_offset = out_q.byte_offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tbl.ready) begin
			valid_s1 <= tbl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl.ready && tbl.valid) begin
			byte_s1 <= tbl.table_byte;
			last_s1 <= tbl.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= start_state(CFG_W'(1));
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid)
			out_q <= res_nxt;
	end

	// a not-found report never carries an offset
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status == ST_NOT_FOUND |-> result.byte_offset == '0)
		else $error("not-found result with nonzero offset");

	// end of table returns the parser to its start
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> state_q.parse_phase == PH_WAIT && !state_q.search_done
			&& state_q.entry_end == '0)
		else $error("table state not restarted after last item");

	// a match inside a table marks the search finished
	a_found_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_valid && res_nxt.status == ST_FOUND && !last_s1
			|=> state_q.search_done)
		else $error("match without search_done");

	// a partial varint shift only exists while a varint is open
	a_shift_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.varint_shift != '0 |-> state_q.parse_phase == PH_VARINT)
		else $error("varint shift outside varint phase");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import lts_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	// expected search results, worked out byte by byte
	class offset_board;
		logic [CFG_W-1:0]  first_line;
		logic [CFG_W-1:0]  target_line;
		logic [LINE_W-1:0] line;
		logic [OFF_W-1:0]  start_off;
		logic [OFF_W-1:0]  end_off;
		logic [LINE_W-1:0] accum;
		logic [SHIFT_W-1:0] shift;
		phase_t            phase;
		bit                done;
		result_t           awaited[$];
		int                errors;

		function void restart();
			line      = {1'b0, first_line};
			start_off = '0;
			end_off   = '0;
			accum     = '0;
			shift     = '0;
			phase     = PH_WAIT;
			done      = 1'b0;
		endfunction

		function void reset_all();
			first_line  = 31'd1;
			target_line = 31'd0;
			errors      = 0;
			awaited.delete();
			restart();
		endfunction

		function void set_register(logic idx, logic [CFG_W-1:0] value);
			if (idx == CFG_FIRST_LINE) begin
				first_line = value;
			end else begin
				target_line = value;
			end
		endfunction

		function int try_hit();
			result_t r;
			if (!done && line == {1'b0, target_line}) begin
				done = 1'b1;
				r.status = ST_FOUND;
				r.byte_offset = start_off;
				awaited.push_back(r);
				return 1;
			end
			return 0;
		endfunction

		// zigzag: bit 0 is the sign, the rest the magnitude
		function int close_delta();
			logic [LINE_W-1:0] mag;
			mag = {1'b0, accum[LINE_W-1:1]};
			line = accum[0] ? line - mag : line + mag;
			accum = '0;
			shift = '0;
			phase = PH_SKIP;
			return try_hit();
		endfunction

		function void take_byte(logic [7:0] b, logic last);
			int n;
			logic [3:0] code;
			logic [31:0] span;
			logic [31:0] chunk;
			result_t r;
			n = 0;
			if (b[7]) begin
				code = b[6:3];
				span = ({29'd0, b[2:0]} + 32'd1) * 32'd2;
				if (phase == PH_VARINT)
					n += close_delta();
				if (end_off == '0)
					line = {1'b0, first_line};
				start_off = end_off;
				if ({1'b0, end_off} > {1'b0, OFF_MAX} - span) begin
					end_off = OFF_MAX;
				end else begin
					end_off = end_off + span[OFF_W-1:0];
				end
				if (code == CODE_DELTA_A || code == CODE_DELTA_B) begin
					accum = '0;
					shift = '0;
					phase = PH_VARINT;
				end else begin
					if (code >= CODE_LINE_ADD0 && code <= CODE_LINE_ADD2)
						line = line + {28'd0, code - CODE_LINE_ADD0};
					phase = PH_SKIP;
					if (code != CODE_NO_LINE && n == 0)
						n += try_hit();
				end
			end else if (phase == PH_VARINT) begin
				if (shift < SHIFT_LIMIT) begin
					chunk = {26'd0, b[5:0]};
					accum = accum | (chunk << shift);
				end
				if (b[6]) begin
					if (shift < SHIFT_CAP)
						shift = shift + SHIFT_STEP;
				end else if (n == 0) begin
					n += close_delta();
				end
			end
			if (last) begin
				if (phase == PH_VARINT && n == 0)
					n += close_delta();
				if (!done && n == 0) begin
					r.status = ST_NOT_FOUND;
					r.byte_offset = '0;
					awaited.push_back(r);
				end
				restart();
			end
		endfunction

		function void check_result(logic status, logic [OFF_W-1:0] byte_offset);
			result_t e;
			if (awaited.size() == 0) begin
				$error("unexpected result: status %0d byte_offset %0d", status, byte_offset);
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, status);
				errors++;
			end
			if (byte_offset !== e.byte_offset) begin
				$error("byte_offset: expected %0d, actual %0d", e.byte_offset, byte_offset);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycle_count;
	int   sent_count;
	bit   calm;

	offset_board board;

	lts_byte_if   tbl_bus();
	lts_result_if res_bus();
	lts_cfg_if    cfg_bus();

	location_table_line_search_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.tbl(tbl_bus),
		.result(res_bus),
		.cfg(cfg_bus)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && cfg_bus.valid && cfg_bus.ready)
			board.set_register(cfg_bus.index, cfg_bus.data);
		if (arst_n && tbl_bus.valid && tbl_bus.ready)
			board.take_byte(tbl_bus.table_byte, tbl_bus.last_byte);
	end

	always @(posedge clk) begin
		if (arst_n && res_bus.valid && res_bus.ready)
			board.check_result(res_bus.status, res_bus.byte_offset);
	end

	// result side: ready drops in bursts, never in the calm tail
	initial begin
		res_bus.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 5) == 0) begin
				res_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic last);
		if (!calm && $urandom_range(0, 6) == 0) begin
			tbl_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		tbl_bus.valid      <= 1'b1;
		tbl_bus.table_byte <= b;
		tbl_bus.last_byte  <= last;
		@(posedge clk);
		while (!tbl_bus.ready) @(posedge clk);
		sent_count++;
	endtask

	// stop the byte stream and let every pending result drain
	task automatic drain_search();
		tbl_bus.valid <= 1'b0;
		@(posedge clk);
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_search(input logic [CFG_W-1:0] first, input logic [CFG_W-1:0] target);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= CFG_FIRST_LINE;
		cfg_bus.data  <= first;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		cfg_bus.index <= CFG_TARGET_LINE;
		cfg_bus.data  <= target;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic send_table();
		logic [7:0]  tbl_bytes[$];
		logic [7:0]  tail;
		logic [3:0]  code;
		logic [31:0] mag;
		logic [31:0] zz;
		logic [5:0]  c;
		int          entries;
		int          pick;
		if ($urandom_range(0, 15) == 0) begin
			// pure noise
			repeat ($urandom_range(1, 10)) tbl_bytes.push_back(8'($urandom));
		end else begin
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 2)) tbl_bytes.push_back({1'b0, 7'($urandom)});
			entries = $urandom_range(1, 10);
			repeat (entries) begin
				pick = $urandom_range(0, 9);
				if (pick <= 2) begin
					code = $urandom_range(0, 1) ? CODE_DELTA_A : CODE_DELTA_B;
				end else if (pick <= 5) begin
					code = 4'($urandom_range(10, 12));
				end else if (pick == 6) begin
					code = CODE_NO_LINE;
				end else begin
					code = 4'($urandom_range(0, 9));
				end
				tbl_bytes.push_back({1'b1, code, 3'($urandom)});
				if (code == CODE_DELTA_A || code == CODE_DELTA_B) begin
					if ($urandom_range(0, 9) == 0) begin
						// long varint, chunks past bit 32 are dropped
						for (int k = 0; k < 7; k++)
							tbl_bytes.push_back({1'b0, k < 6, 6'($urandom)});
					end else begin
						mag = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3);
						zz = {mag[30:0], 1'($urandom)};
						do begin
							c = zz[5:0];
							zz = zz >> 6;
							tbl_bytes.push_back({1'b0, zz != 0, c});
						end while (zz != 0);
					end
					// varint cut short by the next header or the end of table
					if ($urandom_range(0, 11) == 0) begin
						tail = tbl_bytes.pop_back();
						tail[6] = 1'b1;
						tbl_bytes.push_back(tail);
					end
				end
				repeat ($urandom_range(0, 2)) tbl_bytes.push_back({1'b0, 7'($urandom)});
			end
		end
		foreach (tbl_bytes[i])
			push_byte(tbl_bytes[i], i == tbl_bytes.size() - 1);
	endtask

	initial begin
		logic [15:0]      directed[$];
		logic [CFG_W-1:0] f;
		logic [CFG_W-1:0] t;
		int               phase_start;
		board = new();
		board.reset_all();
		cycle_count = 0;
		sent_count = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		tbl_bus.valid = 1'b0;
		tbl_bus.table_byte = '0;
		tbl_bus.last_byte = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = CFG_FIRST_LINE;
		cfg_bus.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray byte, add-line codes, column byte, keep code, delta hit,
		// no-line code, varint cut by a header, long varint, end inside a varint
		directed = {
			16'h0005, 16'h00D0, 16'h00DF, 16'h007F, 16'h0080, 16'h00EB, 16'h0042, 16'h0000,
			16'h00E0, 16'h00F8, 16'h00F1, 16'h0045, 16'h0087, 16'h0100,
			16'h00F2, 16'h007F, 16'h007F, 16'h007F, 16'h007F, 16'h007F, 16'h007F, 16'h003F,
			16'h00E8, 16'h0141
		};
		program_search(31'd5, 31'd7);
		foreach (directed[i])
			push_byte(directed[i][7:0], directed[i][8]);
		drain_search();

		for (int p = 0; p < 7; p++) begin
			case (p)
				0: begin
					f = '0;
					t = '0;
				end
				1: begin
					f = OFF_MAX;
					t = OFF_MAX;
				end
				2: begin
					f = 31'd1;
					t = 31'd3;
				end
				3: begin
					f = 31'($urandom);
					t = f + 31'($urandom_range(0, 4));
				end
				4: begin
					f = OFF_MAX - 31'd2;
					t = '0;
				end
				5: begin
					f = 31'($urandom_range(0, 20));
					t = f + 31'd2;
				end
				default: begin
					f = 31'($urandom);
					t = 31'($urandom);
				end
			endcase
			program_search(f, t);
			phase_start = sent_count;
			while (sent_count - phase_start < 170) begin
				if (sent_count > 1150)
					calm = 1'b1;
				send_table();
			end
			drain_search();
		end

		repeat (4) @(posedge clk);
		if (board.errors == 0 && board.awaited.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== location_table_line_search_core.f =====
design/lts_pkg.sv
design/lts_if.sv
design/lts_cfg.sv
design/lts_step.sv
design/location_table_line_search_core.sv
tb/testbench.sv
